// ===== sv/dkr_pkg.sv =====
package dkr_pkg;

   localparam int DEPTH = 128;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int LVL   = $clog2(DEPTH);
   localparam int ACT_W = 2;
   localparam int KEY_W = 64;
   localparam int PAY_W = 64;

   typedef enum logic [ACT_W-1:0] {
      ACT_PUSH_BACK  = 2'd0,
      ACT_PUSH_FRONT = 2'd1,
      ACT_POP_FRONT  = 2'd2,
      ACT_REMOVE     = 2'd3
   } action_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic             cmp_en;
      logic [KEY_W-1:0] cmp_key;
      logic [CNT_W-1:0] count;
      logic             load_tail;
      logic             push_front;
      logic [KEY_W-1:0] new_key;
      logic [PAY_W-1:0] new_payload;
   } cell_ctrl_type;

endpackage

// ===== sv/dkr_cell.sv =====
module dkr_cell (
   input  logic                       clock,
   input  dkr_pkg::cell_ctrl_type     ctrl,
   input  logic [dkr_pkg::IDX_W-1:0]  cell_idx,
   input  logic [dkr_pkg::KEY_W-1:0]  prev_key,
   input  logic [dkr_pkg::PAY_W-1:0]  prev_payload,
   input  logic [dkr_pkg::KEY_W-1:0]  next_key,
   input  logic [dkr_pkg::PAY_W-1:0]  next_payload,
   input  logic                       shift_fwd,
   output logic [dkr_pkg::KEY_W-1:0]  cell_key,
   output logic [dkr_pkg::PAY_W-1:0]  cell_payload,
   output logic                       match
);
   import dkr_pkg::*;

   logic [KEY_W-1:0] key_ff, key_in;
   logic [PAY_W-1:0] pay_ff, pay_in;
   logic             match_ff, match_in;
   logic             occupied;

   assign occupied = CNT_W'(cell_idx) < ctrl.count;

   always_comb begin
      key_in   = key_ff;
      pay_in   = pay_ff;
      match_in = match_ff;
      if (ctrl.cmp_en) begin
         match_in = occupied && (key_ff == ctrl.cmp_key);
      end
      if (ctrl.push_front) begin
         key_in = prev_key;
         pay_in = prev_payload;
      end else if (ctrl.load_tail && (CNT_W'(cell_idx) == ctrl.count)) begin
         key_in = ctrl.new_key;
         pay_in = ctrl.new_payload;
      end else if (shift_fwd) begin
         key_in = next_key;
         pay_in = next_payload;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      pay_ff   <= pay_in;
      match_ff <= match_in;
   end

   assign cell_key     = key_ff;
   assign cell_payload = pay_ff;
   assign match        = match_ff;

endmodule

// ===== sv/deque_with_keyed_removal_unit.sv =====
// Channel   Direction  Handshake             Transaction
// req_      in         req_valid/req_stall   action, entry key, entry payload
// rsp_      out        rsp_valid/rsp_stall   ok, out key, out payload, fill count
//
// Each transaction passes through an accept cycle, in which every cell compares
// its key against the request, and an execute cycle, in which the row of cells
// shifts, loads or closes the gap and the result register is written.
// The execute cycle waits while a finished result is stalled at rsp_.
// Reset clears the fill count and handshake state; cell contents need none.
module deque_with_keyed_removal_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [dkr_pkg::ACT_W-1:0]  req_action,
   input  logic [dkr_pkg::KEY_W-1:0]  req_entry_key,
   input  logic [dkr_pkg::PAY_W-1:0]  req_entry_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_ok,
   output logic [dkr_pkg::KEY_W-1:0]  rsp_out_key,
   output logic [dkr_pkg::PAY_W-1:0]  rsp_out_payload,
   output logic [dkr_pkg::CNT_W-1:0]  rsp_fill_count
);
   import dkr_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   action_type       act_ff;
   logic [KEY_W-1:0] key_ff;
   logic [PAY_W-1:0] pay_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_ok_ff;
   logic [KEY_W-1:0] rsp_key_ff;
   logic [PAY_W-1:0] rsp_pay_ff;
   logic [CNT_W-1:0] rsp_cnt_ff;

   logic             req_accept, rsp_free, go, ok, found;
   cell_ctrl_type    ctrl;
   logic [KEY_W-1:0] cell_key  [DEPTH];
   logic [PAY_W-1:0] cell_pay  [DEPTH];
   logic [KEY_W-1:0] prev_key  [DEPTH];
   logic [PAY_W-1:0] prev_pay  [DEPTH];
   logic [KEY_W-1:0] next_key  [DEPTH];
   logic [PAY_W-1:0] next_pay  [DEPTH];
   logic [DEPTH-1:0] match, first, sel, shift_fwd;
   logic [DEPTH-1:0] pre [LVL+1];
   logic [KEY_W-1:0] sel_key;
   logic [PAY_W-1:0] sel_pay;

   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign go         = (state_ff == ST_EXEC) && rsp_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_accept) state_in = ST_EXEC;
         ST_EXEC: if (go) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         default: req_stall = 1'b1;
      endcase
   end

   always_comb begin
      pre[0] = match;
      for (int l = 0; l < LVL; l++) begin
         for (int i = 0; i < DEPTH; i++) begin
            if (i >= (1 << l)) begin
               pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
            end else begin
               pre[l+1][i] = pre[l][i];
            end
         end
      end
   end

   assign first = match & ~{pre[LVL][DEPTH-2:0], 1'b0};
   assign found = |match;

   always_comb begin
      case (act_ff)
         ACT_PUSH_BACK, ACT_PUSH_FRONT: ok = count_ff < CNT_W'(DEPTH);
         ACT_POP_FRONT:                 ok = count_ff != '0;
         default:                       ok = found;
      endcase
   end

   always_comb begin
      sel       = first;
      shift_fwd = '0;
      if (act_ff == ACT_POP_FRONT) begin
         sel = DEPTH'(1);
      end
      if (go && ok) begin
         if (act_ff == ACT_POP_FRONT) begin
            shift_fwd = '1;
         end else if (act_ff == ACT_REMOVE) begin
            shift_fwd = pre[LVL];
         end
      end
   end

   always_comb begin
      sel_key = '0;
      sel_pay = '0;
      for (int i = 0; i < DEPTH; i++) begin
         sel_key = sel_key | (cell_key[i] & {KEY_W{sel[i]}});
         sel_pay = sel_pay | (cell_pay[i] & {PAY_W{sel[i]}});
      end
   end

   always_comb begin
      ctrl.cmp_en      = req_accept;
      ctrl.cmp_key     = req_entry_key;
      ctrl.count       = count_ff;
      ctrl.load_tail   = go && ok && (act_ff == ACT_PUSH_BACK);
      ctrl.push_front  = go && ok && (act_ff == ACT_PUSH_FRONT);
      ctrl.new_key     = key_ff;
      ctrl.new_payload = pay_ff;
   end

   always_comb begin
      count_in = count_ff;
      if (go && ok) begin
         case (act_ff)
            ACT_PUSH_BACK, ACT_PUSH_FRONT: count_in = count_ff + 1'b1;
            default:                       count_in = count_ff - 1'b1;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         if (g == 0) begin : g_head
            assign prev_key[g] = key_ff;
            assign prev_pay[g] = pay_ff;
         end else begin : g_body
            assign prev_key[g] = cell_key[g-1];
            assign prev_pay[g] = cell_pay[g-1];
         end
         if (g == DEPTH - 1) begin : g_tail
            assign next_key[g] = cell_key[g];
            assign next_pay[g] = cell_pay[g];
         end else begin : g_mid
            assign next_key[g] = cell_key[g+1];
            assign next_pay[g] = cell_pay[g+1];
         end
         dkr_cell u_cell (
            .clock        (clock),
            .ctrl         (ctrl),
            .cell_idx     (IDX_W'(g)),
            .prev_key     (prev_key[g]),
            .prev_payload (prev_pay[g]),
            .next_key     (next_key[g]),
            .next_payload (next_pay[g]),
            .shift_fwd    (shift_fwd[g]),
            .cell_key     (cell_key[g]),
            .cell_payload (cell_pay[g]),
            .match        (match[g])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         act_ff <= action_type'(req_action);
         key_ff <= req_entry_key;
         pay_ff <= req_entry_payload;
      end
      if (go) begin
         rsp_ok_ff  <= ok;
         rsp_key_ff <= (ok && (act_ff == ACT_POP_FRONT || act_ff == ACT_REMOVE))
                       ? sel_key : '0;
         rsp_pay_ff <= (ok && (act_ff == ACT_POP_FRONT || act_ff == ACT_REMOVE))
                       ? sel_pay : '0;
         rsp_cnt_ff <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_out_payload = rsp_pay_ff;
   assign rsp_fill_count  = rsp_cnt_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      go && ok && (act_ff == ACT_PUSH_BACK || act_ff == ACT_PUSH_FRONT)
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not advance fill count");

   a_first_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> $onehot0(first))
      else $error("more than one first match");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_key_ff == '0 && rsp_pay_ff == '0)
      else $error("failed transaction returned data");

endmodule
